[src/frmdf_pkg.sv]
package frmdf_pkg;

    localparam int unsigned CfgIdxWidth = 3;
    localparam int unsigned LenBytes    = 2;

    localparam logic [CfgIdxWidth-1:0] CFG_HEADER   = 3'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_FOOTER   = 3'd1;
    localparam logic [CfgIdxWidth-1:0] CFG_CMD_TYPE = 3'd2;
    localparam logic [CfgIdxWidth-1:0] CFG_RSP_TYPE = 3'd3;
    localparam logic [CfgIdxWidth-1:0] CFG_NTF_TYPE = 3'd4;

    localparam logic [7:0] HEADER_RESET   = 8'hBB;
    localparam logic [7:0] FOOTER_RESET   = 8'h7E;
    localparam logic [7:0] CMD_TYPE_RESET = 8'h00;
    localparam logic [7:0] RSP_TYPE_RESET = 8'h01;
    localparam logic [7:0] NTF_TYPE_RESET = 8'h02;

    typedef enum logic [6:0] {
        PH_HEADER   = 7'b0000001,
        PH_TYPE     = 7'b0000010,
        PH_COMMAND  = 7'b0000100,
        PH_LENGTH   = 7'b0001000,
        PH_PARAM    = 7'b0010000,
        PH_CHECKSUM = 7'b0100000,
        PH_FOOTER   = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [7:0] header_byte;
        logic [7:0] footer_byte;
        logic [7:0] command_type_code;
        logic [7:0] response_type_code;
        logic [7:0] notify_type_code;
    } cfg_t;

    typedef struct packed {
        logic        param_valid;
        logic [7:0]  param_byte;
        logic [15:0] param_index;
        logic        frame_done;
        logic        frame_error;
        logic [7:0]  frame_kind;
        logic [7:0]  frame_opcode;
        logic [15:0] frame_len;
    } result_t;

endpackage

[src/rfid_module_frame_deframer.sv]
// Frame parser for the serial link of a UHF RFID reader module. Received bytes
// enter on the slave stream, one byte per item, and every byte yields exactly
// one result item on the master stream. A result carries the parameter byte
// and its index when the byte was a parameter, the held type, command and
// length of the current frame, and flags. The tlast bit marks the item of a
// frame whose footer matched; the consumer keeps the parameter bytes of a
// frame only when that item follows them. An abandoned frame sets the error
// flag in tuser.
// A byte passes an input register and then a result register before its
// result item appears on the master stream. One byte is taken in every cycle
// while the receiver does not stall; the state update is a single compare and
// add per byte.
// When the receiver stalls, the result register holds its item and the input
// register takes one more byte, after which s_tready falls.
// Reset empties both registers, returns the parser to waiting for a header,
// clears the held fields and loads the default delimiter and type codes.
// Configuration writes are always accepted and are meant for idle periods.
module rfid_module_frame_deframer
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // rx_byte
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // param_byte, param_index, frame_kind, frame_opcode, frame_len
    output logic [55:0]                         m_tdata,
    output logic                                m_tlast,
    output logic [1:0]                          m_tuser,   // param_valid, frame_error
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [frmdf_pkg::CfgIdxWidth-1:0]   cfg_index,
    input  logic [7:0]                          cfg_data
);

    frmdf_pkg::cfg_t    cfg;
    frmdf_pkg::result_t result;
    frmdf_pkg::result_t out_reg;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    logic       advance;
    logic       step;

    assign advance  = !out_valid_reg || m_tready;
    assign step     = advance && in_valid_reg;
    assign s_tready = !in_valid_reg || advance;

    frmdf_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    frmdf_parser u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .rx_byte (in_byte_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
        end
        if (step)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.frame_len, out_reg.frame_opcode, out_reg.frame_kind,
                       out_reg.param_index, out_reg.param_byte};
    assign m_tlast  = out_reg.frame_done;
    assign m_tuser  = {out_reg.frame_error, out_reg.param_valid};

endmodule

[src/frmdf_cfg.sv]
module frmdf_cfg
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [frmdf_pkg::CfgIdxWidth-1:0]   cfg_index,
    input  logic [7:0]                          cfg_data,
    output frmdf_pkg::cfg_t                     cfg
);

    frmdf_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_byte        <= frmdf_pkg::HEADER_RESET;
            cfg_reg.footer_byte        <= frmdf_pkg::FOOTER_RESET;
            cfg_reg.command_type_code  <= frmdf_pkg::CMD_TYPE_RESET;
            cfg_reg.response_type_code <= frmdf_pkg::RSP_TYPE_RESET;
            cfg_reg.notify_type_code   <= frmdf_pkg::NTF_TYPE_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                frmdf_pkg::CFG_HEADER:   cfg_reg.header_byte        <= cfg_data;
                frmdf_pkg::CFG_FOOTER:   cfg_reg.footer_byte        <= cfg_data;
                frmdf_pkg::CFG_CMD_TYPE: cfg_reg.command_type_code  <= cfg_data;
                frmdf_pkg::CFG_RSP_TYPE: cfg_reg.response_type_code <= cfg_data;
                frmdf_pkg::CFG_NTF_TYPE: cfg_reg.notify_type_code   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

endmodule

[src/frmdf_parser.sv]
module frmdf_parser
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  logic [7:0]              rx_byte,
    input  frmdf_pkg::cfg_t         cfg,
    output frmdf_pkg::result_t      result
);

    frmdf_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  kind_reg, kind_next;
    logic [7:0]  opcode_reg, opcode_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] count_reg, count_next;
    logic [7:0]  sum_reg, sum_next;

    logic        type_ok;
    logic [15:0] count_inc;
    logic [16:0] count_plus_one;

    assign type_ok = (rx_byte == cfg.command_type_code) ||
                     (rx_byte == cfg.response_type_code) ||
                     (rx_byte == cfg.notify_type_code);
    assign count_inc = count_reg + 16'd1;
    assign count_plus_one = {1'b0, count_reg} + 17'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        kind_next   = kind_reg;
        opcode_next = opcode_reg;
        len_next    = len_reg;
        count_next  = count_reg;
        sum_next    = sum_reg;
        result.param_valid = 1'b0;
        result.param_byte  = 8'd0;
        result.param_index = 16'd0;
        result.frame_done  = 1'b0;
        result.frame_error = 1'b0;

        unique case (phase_reg)
            frmdf_pkg::PH_TYPE:
            begin
                if (type_ok)
                begin
                    kind_next  = rx_byte;
                    sum_next   = rx_byte;
                    phase_next = frmdf_pkg::PH_COMMAND;
                end
                else
                begin
                    result.frame_error = 1'b1;
                    phase_next = frmdf_pkg::PH_HEADER;
                end
            end
            frmdf_pkg::PH_COMMAND:
            begin
                opcode_next = rx_byte;
                sum_next    = sum_reg + rx_byte;
                len_next    = 16'd0;
                count_next  = 16'd0;
                phase_next  = frmdf_pkg::PH_LENGTH;
            end
            frmdf_pkg::PH_LENGTH:
            begin
                len_next   = {len_reg[7:0], rx_byte};
                sum_next   = sum_reg + rx_byte;
                count_next = count_inc;
                if (count_inc >= 16'(frmdf_pkg::LenBytes))
                begin
                    count_next = 16'd0;
                    phase_next = (len_next != 16'd0) ? frmdf_pkg::PH_PARAM
                                                     : frmdf_pkg::PH_CHECKSUM;
                end
            end
            frmdf_pkg::PH_PARAM:
            begin
                result.param_valid = 1'b1;
                result.param_byte  = rx_byte;
                result.param_index = count_reg;
                sum_next = sum_reg + rx_byte;
                if (count_plus_one >= {1'b0, len_reg})
                begin
                    count_next = 16'd0;
                    phase_next = frmdf_pkg::PH_CHECKSUM;
                end
                else
                begin
                    count_next = count_inc;
                end
            end
            frmdf_pkg::PH_CHECKSUM:
            begin
                if (rx_byte == sum_reg)
                begin
                    phase_next = frmdf_pkg::PH_FOOTER;
                end
                else
                begin
                    result.frame_error = 1'b1;
                    phase_next = frmdf_pkg::PH_HEADER;
                end
            end
            frmdf_pkg::PH_FOOTER:
            begin
                if (rx_byte == cfg.footer_byte)
                begin
                    result.frame_done = 1'b1;
                end
                else
                begin
                    result.frame_error = 1'b1;
                end
                phase_next = frmdf_pkg::PH_HEADER;
            end
            default:
            begin
                phase_next = (rx_byte == cfg.header_byte) ? frmdf_pkg::PH_TYPE
                                                          : frmdf_pkg::PH_HEADER;
            end
        endcase

        result.frame_kind   = kind_next;
        result.frame_opcode = opcode_next;
        result.frame_len    = len_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= frmdf_pkg::PH_HEADER;
            kind_reg   <= 8'd0;
            opcode_reg <= 8'd0;
            len_reg    <= 16'd0;
            count_reg  <= 16'd0;
            sum_reg    <= 8'd0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            kind_reg   <= kind_next;
            opcode_reg <= opcode_next;
            len_reg    <= len_next;
            count_reg  <= count_next;
            sum_reg    <= sum_next;
        end
    end

endmodule

[tb/testbench.sv]
module testbench;

    import frmdf_pkg::*;

    localparam int QuietLimit = 2000;
    localparam int HoldCycles = 150;
    localparam int PhaseBytes = 420;

    typedef struct {
        logic [7:0] rx;
        bit         known;
        result_t    want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic m_tlast;
    logic [1:0] m_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CfgIdxWidth-1:0] cfg_index = CFG_HEADER;
    logic [7:0] cfg_data = 8'h00;

    cfg_t link_cfg;
    phase_t ph;
    logic [7:0] cur_kind;
    logic [7:0] cur_opcode;
    logic [15:0] cur_len;
    logic [15:0] idx_cnt;
    logic [7:0] csum;

    result_t pending_res[$];
    result_t seen_res;
    dir_row_t dir_rows[0:26];

    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    int holds_asked = 0;
    int holds_done = 0;
    int hold_left = 0;
    int stall_left = 0;
    int quiet_cycles = 0;
    int mismatches = 0;
    int bytes_sent = 0;
    int results_seen = 0;
    int frames_done = 0;
    int frames_dropped = 0;
    int params_seen = 0;
    int reg_writes = 0;

    rfid_module_frame_deframer u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic string show_res(input result_t r);
        return $sformatf("pv=%0d pb=%02h pi=%04h done=%0d err=%0d kind=%02h op=%02h len=%04h",
                         r.param_valid, r.param_byte, r.param_index, r.frame_done,
                         r.frame_error, r.frame_kind, r.frame_opcode, r.frame_len);
    endfunction

    function automatic bit is_kind_code(input logic [7:0] b);
        return b == link_cfg.command_type_code || b == link_cfg.response_type_code ||
               b == link_cfg.notify_type_code;
    endfunction

    function automatic result_t parse_byte(input logic [7:0] b);
        result_t r;
        r = '0;
        case (ph)
            PH_TYPE:
            begin
                if (is_kind_code(b))
                begin
                    cur_kind = b;
                    csum = b;
                    ph = PH_COMMAND;
                end
                else
                begin
                    r.frame_error = 1'b1;
                    ph = PH_HEADER;
                end
            end
            PH_COMMAND:
            begin
                cur_opcode = b;
                csum = csum + b;
                cur_len = 16'h0000;
                idx_cnt = 16'h0000;
                ph = PH_LENGTH;
            end
            PH_LENGTH:
            begin
                cur_len = {cur_len[7:0], b};
                csum = csum + b;
                idx_cnt = idx_cnt + 16'd1;
                if (idx_cnt >= LenBytes)
                begin
                    idx_cnt = 16'h0000;
                    ph = (cur_len != 16'h0000) ? PH_PARAM : PH_CHECKSUM;
                end
            end
            PH_PARAM:
            begin
                r.param_valid = 1'b1;
                r.param_byte = b;
                r.param_index = idx_cnt;
                csum = csum + b;
                if ({1'b0, idx_cnt} + 17'd1 >= {1'b0, cur_len})
                begin
                    idx_cnt = 16'h0000;
                    ph = PH_CHECKSUM;
                end
                else
                begin
                    idx_cnt = idx_cnt + 16'd1;
                end
            end
            PH_CHECKSUM:
            begin
                if (b == csum)
                begin
                    ph = PH_FOOTER;
                end
                else
                begin
                    r.frame_error = 1'b1;
                    ph = PH_HEADER;
                end
            end
            PH_FOOTER:
            begin
                if (b == link_cfg.footer_byte)
                    r.frame_done = 1'b1;
                else
                    r.frame_error = 1'b1;
                ph = PH_HEADER;
            end
            default:
            begin
                ph = (b == link_cfg.header_byte) ? PH_TYPE : PH_HEADER;
            end
        endcase
        r.frame_kind = cur_kind;
        r.frame_opcode = cur_opcode;
        r.frame_len = cur_len;
        return r;
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit known = 1'b0,
                             input result_t want = '0);
        int gap;
        result_t r;
        if (tx_idle_en && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 16);
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= b;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        r = parse_byte(b);
        pending_res.push_back(known ? want : r);
        bytes_sent++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_res.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            CFG_HEADER:   link_cfg.header_byte = val;
            CFG_FOOTER:   link_cfg.footer_byte = val;
            CFG_CMD_TYPE: link_cfg.command_type_code = val;
            CFG_RSP_TYPE: link_cfg.response_type_code = val;
            CFG_NTF_TYPE: link_cfg.notify_type_code = val;
            default: ;
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_setting(input logic [7:0] hdr, input logic [7:0] ftr,
                                input logic [7:0] cmd, input logic [7:0] rsp,
                                input logic [7:0] ntf);
        write_reg(CFG_HEADER, hdr);
        write_reg(CFG_FOOTER, ftr);
        write_reg(CFG_CMD_TYPE, cmd);
        write_reg(CFG_RSP_TYPE, rsp);
        write_reg(CFG_NTF_TYPE, ntf);
    endtask

    function automatic logic [7:0] pick_other(input logic [7:0] avoid_a,
                                              input logic [7:0] avoid_b);
        logic [7:0] b;
        do
            b = 8'($urandom);
        while (b == avoid_a || b == avoid_b);
        return b;
    endfunction

    // Frames are mostly well formed; a share of them carries a bad type, a bad
    // checksum or a wrong footer. Stray bytes and bad footers never repeat the
    // header, so a broken frame cannot start a runaway parameter phase.
    task automatic send_frame(input bit allow_long);
        int unsigned roll;
        int unsigned flaw;
        int unsigned i;
        logic [7:0] kind;
        logic [7:0] opcode;
        logic [7:0] sum;
        logic [7:0] b;
        logic [15:0] len;
        roll = $urandom_range(0, 99);
        if (roll < 6)
            len = 16'd0;
        else if (roll < 90)
            len = 16'($urandom_range(1, 8));
        else if (roll < 99 || !allow_long)
            len = 16'($urandom_range(9, 40));
        else
            len = 16'($urandom_range(256, 270));
        flaw = $urandom_range(0, 11);
        repeat ($urandom_range(0, 2))
            send_byte(pick_other(link_cfg.header_byte, link_cfg.header_byte));
        send_byte(link_cfg.header_byte);
        if (flaw == 0)
        begin
            if (!is_kind_code(link_cfg.header_byte) && $urandom_range(0, 3) == 0)
            begin
                b = link_cfg.header_byte;
            end
            else
            begin
                do
                    b = 8'($urandom);
                while (is_kind_code(b));
            end
            send_byte(b);
            return;
        end
        case ($urandom_range(0, 2))
            0: kind = link_cfg.command_type_code;
            1: kind = link_cfg.response_type_code;
            default: kind = link_cfg.notify_type_code;
        endcase
        opcode = 8'($urandom);
        sum = kind + opcode + len[15:8] + len[7:0];
        send_byte(kind);
        send_byte(opcode);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        for (i = 0; i < len; i++)
        begin
            b = 8'($urandom);
            sum = sum + b;
            send_byte(b);
        end
        if (flaw == 1)
        begin
            if (link_cfg.header_byte != sum && $urandom_range(0, 2) == 0)
                b = link_cfg.header_byte;
            else
                b = sum + 8'($urandom_range(1, 255));
            send_byte(b);
            return;
        end
        send_byte(sum);
        if (flaw == 2)
            send_byte(pick_other(link_cfg.footer_byte, link_cfg.header_byte));
        else
            send_byte(link_cfg.footer_byte);
    endtask

    always @(negedge clk)
    begin
        if (holds_asked != holds_done)
        begin
            hold_left = HoldCycles;
            holds_done = holds_asked;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (rx_idle_en && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(1, 16) - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            seen_res.param_valid = m_tuser[0];
            seen_res.frame_error = m_tuser[1];
            seen_res.frame_done = m_tlast;
            seen_res.param_byte = m_tdata[7:0];
            seen_res.param_index = m_tdata[23:8];
            seen_res.frame_kind = m_tdata[31:24];
            seen_res.frame_opcode = m_tdata[39:32];
            seen_res.frame_len = m_tdata[55:40];
            results_seen++;
            if (pending_res.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result item: %s", show_res(seen_res));
            end
            else
            begin
                want = pending_res.pop_front();
                frames_done += want.frame_done;
                frames_dropped += want.frame_error;
                params_seen += want.param_valid;
                if (seen_res !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Result %0d mismatch\n  expected %s\n  actual   %s",
                                 results_seen, show_res(want), show_res(seen_res));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QuietLimit)
            begin
                $display("Timeout after %0d cycles without a handshake, %0d results pending.",
                         quiet_cycles, pending_res.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int target;
        int k;
        link_cfg = '{HEADER_RESET, FOOTER_RESET, CMD_TYPE_RESET, RSP_TYPE_RESET,
                     NTF_TYPE_RESET};
        ph = PH_HEADER;
        cur_kind = 8'h00;
        cur_opcode = 8'h00;
        cur_len = 16'h0000;
        idx_cnt = 16'h0000;
        csum = 8'h00;
        dir_rows = '{
            '{8'h55, 1'b1, result_t'('0)},
            '{8'hBB, 1'b1, result_t'('0)},
            '{8'h05, 1'b1, result_t'{1'b0, 8'h00, 16'h0, 1'b0, 1'b1, 8'h00, 8'h00, 16'h0}},
            '{8'hBB, 1'b1, result_t'('0)},
            '{8'h00, 1'b0, result_t'('0)},
            '{8'hFF, 1'b0, result_t'('0)},
            '{8'h00, 1'b0, result_t'('0)},
            '{8'h00, 1'b0, result_t'('0)},
            '{8'hFF, 1'b0, result_t'('0)},
            '{8'h7E, 1'b1, result_t'{1'b0, 8'h00, 16'h0, 1'b1, 1'b0, 8'h00, 8'hFF, 16'h0}},
            '{8'hBB, 1'b0, result_t'('0)},
            '{8'h02, 1'b0, result_t'('0)},
            '{8'h10, 1'b0, result_t'('0)},
            '{8'h00, 1'b0, result_t'('0)},
            '{8'h02, 1'b0, result_t'('0)},
            '{8'h00, 1'b0, result_t'('0)},
            '{8'hFF, 1'b0, result_t'('0)},
            '{8'h13, 1'b0, result_t'('0)},
            '{8'h7F, 1'b1, result_t'{1'b0, 8'h00, 16'h0, 1'b0, 1'b1, 8'h02, 8'h10, 16'h2}},
            '{8'hBB, 1'b0, result_t'('0)},
            '{8'h01, 1'b0, result_t'('0)},
            '{8'h00, 1'b0, result_t'('0)},
            '{8'h00, 1'b0, result_t'('0)},
            '{8'h00, 1'b0, result_t'('0)},
            '{8'hBB, 1'b1, result_t'{1'b0, 8'h00, 16'h0, 1'b0, 1'b1, 8'h01, 8'h00, 16'h0}},
            '{8'hBB, 1'b1, result_t'{1'b0, 8'h00, 16'h0, 1'b0, 1'b0, 8'h01, 8'h00, 16'h0}},
            '{8'hBB, 1'b1, result_t'{1'b0, 8'h00, 16'h0, 1'b0, 1'b1, 8'h01, 8'h00, 16'h0}}
        };
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (k = 0; k < 27; k++)
            send_byte(dir_rows[k].rx, dir_rows[k].known, dir_rows[k].want);

        for (int p = 0; p < 4; p++)
        begin
            wait_idle();
            case (p)
                0: load_setting(8'h00, 8'hFF, 8'hFF, 8'h80, 8'h7F);
                1: load_setting(8'hFF, 8'h00, 8'h00, 8'h00, 8'h00);
                2: load_setting(8'h5A, 8'hA5, pick_other(8'h5A, 8'h5A),
                                pick_other(8'h5A, 8'h5A), pick_other(8'h5A, 8'h5A));
                default: load_setting(HEADER_RESET, FOOTER_RESET, CMD_TYPE_RESET,
                                      RSP_TYPE_RESET, NTF_TYPE_RESET);
            endcase
            if (p == 0)
                holds_asked++;
            if (p == 3)
            begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            target = bytes_sent + PhaseBytes;
            while (bytes_sent < target)
                send_frame(p != 1);
        end

        wait_idle();
        repeat (8) @(posedge clk);
        $display("Sent %0d bytes under 5 register settings (%0d writes); checked %0d results.",
                 bytes_sent, reg_writes, results_seen);
        $display("Frames completed %0d, frames abandoned %0d, parameter bytes %0d.",
                 frames_done, frames_dropped, params_seen);
        if (mismatches == 0 && pending_res.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[sim.f]
src/frmdf_pkg.sv
src/frmdf_cfg.sv
src/frmdf_parser.sv
src/rfid_module_frame_deframer.sv
tb/testbench.sv
